### design/assert_macros.svh
// assertion macros used by xor_keystream_base64_encoder_top
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### design/xkb_pkg.sv
// shared types, constants and the base64 alphabet lookup
// used by xkb_encoder and xor_keystream_base64_encoder_top
package xkb_pkg;

   localparam int KEY_BYTES_DEF = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 2;
   localparam int KEY_LEN_W     = 4;
   localparam int KEY_POS_W     = 3;
   localparam int MAX_CHARS     = 4;
   localparam int COUNT_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } chars_type;

   // standard base64 alphabet: A-Z a-z 0-9 + /
   function automatic logic [7:0] b64_char(input logic [5:0] six);
      logic [7:0] ch;
      if (six < 6'd26) begin
         ch = 8'h41 + {2'b00, six};
      end else if (six < 6'd52) begin
         ch = 8'h61 + {2'b00, six - 6'd26};
      end else if (six < 6'd62) begin
         ch = 8'h30 + {2'b00, six - 6'd52};
      end else if (six == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

### design/xkb_encoder.sv
// key xor and base64 group encoding for one byte, with the stream state
// depends on xkb_pkg
module xkb_encoder #(
   parameter int KEY_BYTES = xkb_pkg::KEY_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          last_byte,
   input  logic [KEY_BYTES*8-1:0]        key,
   input  logic [xkb_pkg::KEY_LEN_W-1:0] key_length,
   output xkb_pkg::chars_type            item
);

   localparam logic [xkb_pkg::KEY_LEN_W-1:0] KeyMax = xkb_pkg::KEY_LEN_W'(KEY_BYTES);

   logic [xkb_pkg::KEY_POS_W-1:0] key_pos_ff, key_pos_in;
   logic [1:0]                    group_ff, group_in;
   logic [3:0]                    left_ff, left_in;

   logic [xkb_pkg::KEY_LEN_W-1:0] len;
   logic [xkb_pkg::KEY_LEN_W-1:0] idx;
   logic [xkb_pkg::KEY_LEN_W-1:0] nidx;
   logic [7:0]                    ksel;
   logic [7:0]                    b;

   always_comb begin
      len = (key_length > KeyMax) ? KeyMax : key_length;
      idx = ({1'b0, key_pos_ff} >= len) ? '0 : {1'b0, key_pos_ff};
      ksel = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (idx == xkb_pkg::KEY_LEN_W'(i)) begin
            ksel = key[i*8 +: 8];
         end
      end
      b = (len != '0) ? (data_byte ^ ksel) : data_byte;
      nidx = idx + 1'b1;
      if (nidx >= len) begin
         nidx = '0;
      end
      key_pos_in = (len != '0) ? nidx[xkb_pkg::KEY_POS_W-1:0] : key_pos_ff;

      item = '0;
      item.last = last_byte;
      case (group_ff)
         2'd1: begin
            item.chars[0] = xkb_pkg::b64_char({left_ff[1:0], b[7:4]});
            item.count    = 3'd1;
            left_in       = b[3:0];
            group_in      = 2'd2;
            if (last_byte) begin
               item.chars[1] = xkb_pkg::b64_char({b[3:0], 2'b00});
               item.chars[2] = xkb_pkg::PAD_CHAR;
               item.count    = 3'd3;
            end
         end
         2'd2: begin
            item.chars[0] = xkb_pkg::b64_char({left_ff, b[7:6]});
            item.chars[1] = xkb_pkg::b64_char(b[5:0]);
            item.count    = 3'd2;
            left_in       = '0;
            group_in      = 2'd0;
         end
         default: begin
            item.chars[0] = xkb_pkg::b64_char(b[7:2]);
            item.count    = 3'd1;
            left_in       = {2'b00, b[1:0]};
            group_in      = 2'd1;
            if (last_byte) begin
               item.chars[1] = xkb_pkg::b64_char({b[1:0], 4'b0000});
               item.chars[2] = xkb_pkg::PAD_CHAR;
               item.chars[3] = xkb_pkg::PAD_CHAR;
               item.count    = 3'd4;
            end
         end
      endcase

      // end of stream returns to the start of a group and of the key
      if (last_byte) begin
         key_pos_in = '0;
         group_in   = '0;
         left_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
         group_ff   <= '0;
         left_ff    <= '0;
      end else if (accept) begin
         key_pos_ff <= key_pos_in;
         group_ff   <= group_in;
         left_ff    <= left_in;
      end
   end

endmodule

### design/xor_keystream_base64_encoder_top.sv
// Repeating-key xor followed by base64 encoding of a byte stream. Each
// accepted byte is encoded at once into one, two or, on the last byte, up
// to four characters, which leave one per cycle, while rsp_stall is low,
// from a four-entry shift register. A byte yields one or two characters
// in mid-stream (four per three bytes on average) and two to four on a
// last byte. The next byte is accepted in the same cycle as the final
// character of the previous one is taken.
// depends on xkb_pkg, xkb_encoder and assert_macros.svh
`include "assert_macros.svh"

module xor_keystream_base64_encoder_top #(
   parameter int KEY_BYTES = xkb_pkg::KEY_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_char,
   output logic                            rsp_last_char,
   input  logic                            csr_wr_en,
   input  logic [xkb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xkb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [KEY_BYTES*8-1:0]                  key_ff;
   logic [xkb_pkg::KEY_LEN_W-1:0]           key_len_ff;
   logic [xkb_pkg::MAX_CHARS-1:0][7:0]      chars_ff, chars_in;
   logic [xkb_pkg::COUNT_W-1:0]             count_ff, count_in;
   logic                                    last_ff, last_in;
   logic                                    req_acc, rsp_acc;
   xkb_pkg::chars_type                      item;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         key_len_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            xkb_pkg::CSR_KEY_BYTES:  key_ff     <= csr_wdata[KEY_BYTES*8-1:0];
            xkb_pkg::CSR_KEY_LENGTH: key_len_ff <= csr_wdata[xkb_pkg::KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid     = (count_ff != '0);
   assign rsp_acc       = rsp_valid && !rsp_stall;
   assign rsp_out_char  = chars_ff[0];
   assign rsp_last_char = last_ff && (count_ff == 3'd1);
   // free when empty or when the final character leaves this cycle
   assign req_stall     = !((count_ff == '0) || ((count_ff == 3'd1) && !rsp_stall));
   assign req_acc       = req_valid && !req_stall;

   xkb_encoder #(
      .KEY_BYTES (KEY_BYTES)
   ) u_encoder (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_acc),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .key        (key_ff),
      .key_length (key_len_ff),
      .item       (item)
   );

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (req_acc) begin
         chars_in = item.chars;
         count_in = item.count;
         last_in  = item.last;
      end else if (rsp_acc) begin
         for (int i = 0; i < xkb_pkg::MAX_CHARS - 1; i++) begin
            chars_in[i] = chars_ff[i+1];
         end
         chars_in[xkb_pkg::MAX_CHARS-1] = '0;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   `ASSERT_PROP(a_acc_fills, clock, reset, req_acc |=> rsp_valid, "accepted byte gave no char")
   `ASSERT_NEVER(a_count_max, clock, reset, count_ff > 3'd4, "char count above four")
   `ASSERT_NEVER(a_no_overrun, clock, reset, (count_ff > 3'd1) && !req_stall, "accept while busy")
   `ASSERT_PROP(a_drain, clock, reset, (rsp_acc && (count_ff > 3'd1)) |=>
      (count_ff == $past(count_ff) - 3'd1), "char count did not step down")

endmodule
